// ----- rtl/ffha_pkg.sv -----
// Shared types, constants and helpers for the first-fit heap allocator.
package ffha_pkg;

  localparam int ARENA_GRANULES = 1024;
  localparam int GRANULE_SHIFT  = 4;
  localparam int HDR_GRANULES   = 2;
  localparam int IDX_W          = 10;
  localparam int START_W        = 11;
  localparam int PAY_W          = 10;
  localparam int BYTE_W         = 15;
  localparam int CNT_W          = 11;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [START_W-1:0] start_t;
  typedef logic [PAY_W-1:0]   pay_t;
  typedef logic [BYTE_W-1:0]  bytes_t;

  // one side-table entry, kept at the starting granule of each block
  typedef struct packed {
    logic valid;
    logic free;
    pay_t pay;
    idx_t prev;
  } entry_t;

  typedef enum logic [2:0] {
    REQ_FORMAT  = 3'd0,
    REQ_ALLOC   = 3'd1,
    REQ_RELEASE = 3'd2,
    REQ_REALLOC = 3'd3,
    REQ_USABLE  = 3'd4,
    REQ_STATS   = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    STS_DONE    = 2'd0,
    STS_FAILED  = 2'd1,
    STS_IGNORED = 2'd2
  } status_e;

  function automatic start_t next_start(start_t s, pay_t pay);
    return s + START_W'(HDR_GRANULES) + START_W'(pay);
  endfunction

  function automatic bytes_t gran_bytes(start_t g);
    return BYTE_W'({g, {GRANULE_SHIFT{1'b0}}});
  endfunction

endpackage

// ----- rtl/ffha_table.sv -----
// Block side table: one write port, one read port with registered read data.
module ffha_table (
  input  logic            clk_i,
  input  logic            we_i,
  input  ffha_pkg::idx_t   waddr_i,
  input  ffha_pkg::entry_t wdata_i,
  input  ffha_pkg::idx_t   raddr_i,
  output ffha_pkg::entry_t rdata_o
);
  import ffha_pkg::*;

  entry_t mem [ARENA_GRANULES];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/first_fit_heap_allocator.sv -----
// Top level: request sequencer of the first-fit heap allocator.
//
// Requests arrive on the s_axis channel (tuser = request type, tdata = address
// and byte count); one result leaves on the m_axis channel per request
// (tuser = status, tdata = result address, copy bytes, usable bytes and the
// statistics fields). The block takes one request at a time: s_axis_tready_o
// is high only while the sequencer is idle.
// Every step goes through the side table (one write port, one read port),
// whose read data is registered. Allocate and statistics walk the block
// chain; format clears all 1024 table entries, one entry a cycle.
// Reallocate that moves costs an allocate walk plus a release.
// After reset the arena is unformatted and the table contents are don't care;
// format clears the valid marks before anything reads them.
// The result sits in an output register: the next request is taken while it
// waits, and the sequencer holds a new result until the receiver takes it.
module first_fit_heap_allocator (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [63:0]  s_axis_tdata_i,   // address[31:0], size_bytes[63:32]
  input  logic [2:0]   s_axis_tuser_i,   // req_type
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // result_address[31:0], copy_bytes[46:32], usable_bytes[61:47],
  // stat_capacity[76:62], stat_allocations[87:77], stat_free[102:88],
  // stat_used[117:103], stat_largest_free[132:118], zero pad [135:133]
  output logic [135:0] m_axis_tdata_o,
  output logic [1:0]   m_axis_tuser_o    // status
);
  import ffha_pkg::*;

  typedef enum logic [23:0] {
    S_IDLE     = 24'h000001,
    S_DSP      = 24'h000002,
    S_FMT_CLR  = 24'h000004,
    S_FMT_INIT = 24'h000008,
    S_A_RD     = 24'h000010,
    S_A_CHK    = 24'h000020,
    S_A_FIN    = 24'h000040,
    S_SP0      = 24'h000080,
    S_SP1      = 24'h000100,
    S_SP2      = 24'h000200,
    S_SP3      = 24'h000400,
    S_LK_RD    = 24'h000800,
    S_LK_CHK   = 24'h001000,
    S_RA_CHK   = 24'h002000,
    S_M0       = 24'h004000,
    S_M1       = 24'h008000,
    S_M2       = 24'h010000,
    S_M3       = 24'h020000,
    S_M4       = 24'h040000,
    S_R_PREV   = 24'h080000,
    S_R_P1     = 24'h100000,
    S_ST_RD    = 24'h200000,
    S_ST_CHK   = 24'h400000,
    S_RESP     = 24'h800000
  } state_e;

  state_e state_q, state_d, ret_q, ret_d;
  logic [2:0]  req_q, req_d;
  logic [31:0] addr_q, addr_d, size_q, size_d;
  start_t cur_q, cur_d, s_q, s_d, n_q, n_d, r_q, r_d;
  entry_t cure_q, cure_d;
  logic   move_q, move_d, alloc_q, alloc_d;
  bytes_t copy_q, copy_d;
  idx_t   clr_q, clr_d;
  logic [31:0] arena_start_q, arena_start_d;
  start_t ag_q, ag_d;
  logic [CNT_W-1:0] live_q, live_d;
  logic   formatted_q, formatted_d;
  start_t fr_q, fr_d, us_q, us_d;
  pay_t   lg_q, lg_d;

  logic [1:0]  res_status_q, res_status_d;
  logic [31:0] res_addr_q, res_addr_d;
  bytes_t res_copy_q, res_copy_d, res_usable_q, res_usable_d, res_cap_q, res_cap_d;
  logic [CNT_W-1:0] res_alloc_q, res_alloc_d;
  bytes_t res_free_q, res_free_d, res_used_q, res_used_d, res_lg_q, res_lg_d;

  logic         m_tvalid_q, m_tvalid_d;
  logic [135:0] m_tdata_q, m_tdata_d;
  logic [1:0]   m_tuser_q, m_tuser_d;

  logic   mem_we;
  idx_t   mem_waddr, mem_raddr;
  entry_t mem_wdata, rd;

  ffha_table u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (rd)
  );

  // rounded-up granule count of the request, saturated
  logic [32:0] need_full;
  start_t      need_c;
  assign need_full = ({1'b0, size_q} + 33'((1 << GRANULE_SHIFT) - 1)) >> GRANULE_SHIFT;
  assign need_c    = (|need_full[32:START_W]) ? '1 : need_full[START_W-1:0];

  // format arithmetic
  logic [GRANULE_SHIFT-1:0] adj_c;
  logic [32:0] aligned_c;
  logic        fmt_fail;
  logic [31:0] gran_full;
  start_t      gran_c;
  assign adj_c     = GRANULE_SHIFT'(0) - addr_q[GRANULE_SHIFT-1:0];
  assign aligned_c = {1'b0, addr_q} + 33'(adj_c);
  assign fmt_fail  = {1'b0, size_q} <=
                     33'(adj_c) + 33'((HDR_GRANULES + 1) << GRANULE_SHIFT);
  assign gran_full = (size_q - 32'(adj_c)) >> GRANULE_SHIFT;
  assign gran_c    = (gran_full > 32'(ARENA_GRANULES)) ? START_W'(ARENA_GRANULES)
                                                        : gran_full[START_W-1:0];

  // payload address check
  logic [31:0] off_c;
  logic        lk_ok;
  idx_t        lk_g;
  assign off_c = addr_q - arena_start_q;
  assign lk_ok = (addr_q != '0) && formatted_q &&
                 (off_c >= 32'(HDR_GRANULES << GRANULE_SHIFT)) &&
                 (off_c < 32'(gran_bytes(ag_q))) &&
                 (off_c[GRANULE_SHIFT-1:0] == '0);
  assign lk_g  = off_c[GRANULE_SHIFT +: IDX_W] - IDX_W'(HDR_GRANULES);

  logic rel_mode, real_mode;
  assign rel_mode  = (req_q == REQ_RELEASE) ||
                     ((req_q == REQ_REALLOC) && ((size_q == '0) || move_q));
  assign real_mode = (req_q == REQ_REALLOC) && !rel_mode;

  always_comb begin
    start_t t_next;
    start_t t_r;
    pay_t   t_pay;
    entry_t t_ent;
    logic [START_W:0] t_sum;
    bytes_t t_bytes;

    state_d = state_q; ret_d = ret_q; req_d = req_q; addr_d = addr_q; size_d = size_q;
    cur_d = cur_q; s_d = s_q; n_d = n_q; r_d = r_q; cure_d = cure_q;
    move_d = move_q; alloc_d = alloc_q; copy_d = copy_q; clr_d = clr_q;
    arena_start_d = arena_start_q; ag_d = ag_q; live_d = live_q; formatted_d = formatted_q;
    fr_d = fr_q; us_d = us_q; lg_d = lg_q;
    res_status_d = res_status_q; res_addr_d = res_addr_q; res_copy_d = res_copy_q;
    res_usable_d = res_usable_q; res_cap_d = res_cap_q; res_alloc_d = res_alloc_q;
    res_free_d = res_free_q; res_used_d = res_used_q; res_lg_d = res_lg_q;
    m_tvalid_d = m_tvalid_q && !m_axis_tready_i;
    m_tdata_d  = m_tdata_q;
    m_tuser_d  = m_tuser_q;
    mem_we = 1'b0; mem_waddr = '0; mem_wdata = '0; mem_raddr = '0;
    t_next = '0; t_r = '0; t_pay = '0; t_ent = '0; t_sum = '0; t_bytes = '0;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          req_d  = s_axis_tuser_i;
          addr_d = s_axis_tdata_i[31:0];
          size_d = s_axis_tdata_i[63:32];
          move_d = 1'b0;
          alloc_d = 1'b0;
          res_status_d = STS_DONE; res_addr_d = '0; res_copy_d = '0; res_usable_d = '0;
          res_cap_d = '0; res_alloc_d = '0; res_free_d = '0; res_used_d = '0;
          res_lg_d = '0;
          state_d = S_DSP;
        end
      end
      S_DSP: begin
        case (req_q)
          REQ_FORMAT: begin
            if (fmt_fail) begin
              res_status_d = STS_FAILED;
              state_d = S_RESP;
            end else begin
              clr_d = '0;
              state_d = S_FMT_CLR;
            end
          end
          REQ_ALLOC, REQ_REALLOC: begin
            if (req_q == REQ_REALLOC && addr_q != '0) begin
              state_d = S_LK_RD;
            end else if (size_q == '0 || !formatted_q) begin
              res_status_d = STS_FAILED;
              state_d = S_RESP;
            end else begin
              s_d = '0;
              alloc_d = 1'b1;
              state_d = S_A_RD;
            end
          end
          REQ_RELEASE, REQ_USABLE: state_d = S_LK_RD;
          REQ_STATS: begin
            if (!formatted_q) begin
              state_d = S_RESP;
            end else begin
              s_d = '0; fr_d = '0; us_d = '0; lg_d = '0;
              state_d = S_ST_RD;
            end
          end
          default: begin
            res_status_d = STS_IGNORED;
            state_d = S_RESP;
          end
        endcase
      end
      S_FMT_CLR: begin
        mem_we = 1'b1;
        mem_waddr = clr_q;
        clr_d = clr_q + 1'b1;
        if (clr_q == '1) state_d = S_FMT_INIT;
      end
      S_FMT_INIT: begin
        t_ent.valid = 1'b1;
        t_ent.free  = 1'b1;
        t_ent.pay   = PAY_W'(gran_c - START_W'(HDR_GRANULES));
        t_ent.prev  = '0;
        mem_we = 1'b1;
        mem_waddr = '0;
        mem_wdata = t_ent;
        arena_start_d = aligned_c[31:0];
        ag_d = gran_c;
        live_d = '0;
        formatted_d = 1'b1;
        state_d = S_RESP;
      end
      S_A_RD: begin
        if (s_q < ag_q) begin
          mem_raddr = s_q[IDX_W-1:0];
          state_d = S_A_CHK;
        end else begin
          res_status_d = STS_FAILED;
          state_d = S_RESP;
        end
      end
      S_A_CHK: begin
        if (!rd.valid) begin
          res_status_d = STS_FAILED;
          state_d = S_RESP;
        end else if (rd.free && START_W'(rd.pay) >= need_c) begin
          cur_d = s_q;
          cure_d = rd;
          cure_d.free = 1'b0;
          state_d = S_SP0;
        end else begin
          s_d = next_start(s_q, rd.pay);
          state_d = S_A_RD;
        end
      end
      S_SP0: begin
        // split only when the remainder can hold a header and one granule
        if ({1'b0, START_W'(cure_q.pay)} >= {1'b0, need_c} + (START_W+1)'(HDR_GRANULES + 1)) begin
          t_r = cur_q + START_W'(HDR_GRANULES) + need_c;
          t_ent.valid = 1'b1;
          t_ent.free  = 1'b1;
          t_ent.pay   = cure_q.pay - PAY_W'(need_c) - PAY_W'(HDR_GRANULES);
          t_ent.prev  = cur_q[IDX_W-1:0];
          mem_we = 1'b1;
          mem_waddr = t_r[IDX_W-1:0];
          mem_wdata = t_ent;
          r_d = t_r;
          n_d = next_start(cur_q, cure_q.pay);
          cure_d.pay = PAY_W'(need_c);
          state_d = S_SP1;
        end else begin
          state_d = S_SP3;
        end
      end
      S_SP1: begin
        if (n_q < ag_q) begin
          mem_raddr = n_q[IDX_W-1:0];
          state_d = S_SP2;
        end else begin
          state_d = S_SP3;
        end
      end
      S_SP2: begin
        if (rd.valid) begin
          t_ent = rd;
          t_ent.prev = r_q[IDX_W-1:0];
          mem_we = 1'b1;
          mem_waddr = n_q[IDX_W-1:0];
          mem_wdata = t_ent;
        end
        state_d = S_SP3;
      end
      S_SP3: begin
        mem_we = 1'b1;
        mem_waddr = cur_q[IDX_W-1:0];
        mem_wdata = cure_q;
        state_d = alloc_q ? S_A_FIN : S_RESP;
      end
      S_A_FIN: begin
        live_d = live_q + 1'b1;
        res_addr_d = arena_start_q +
                     (32'(cur_q + START_W'(HDR_GRANULES)) << GRANULE_SHIFT);
        alloc_d = 1'b0;
        if (move_q) begin
          res_copy_d = copy_q;
          state_d = S_LK_RD;   // now release the old block
        end else begin
          state_d = S_RESP;
        end
      end
      S_LK_RD: begin
        if (lk_ok) begin
          mem_raddr = lk_g;
          state_d = S_LK_CHK;
        end else begin
          if (!move_q) res_status_d = STS_IGNORED;
          state_d = S_RESP;
        end
      end
      S_LK_CHK: begin
        if (!rd.valid || rd.free) begin
          if (!move_q) res_status_d = STS_IGNORED;
          state_d = S_RESP;
        end else if (rel_mode) begin
          t_ent = rd;
          t_ent.free = 1'b1;
          mem_we = 1'b1;
          mem_waddr = lk_g;
          mem_wdata = t_ent;
          cur_d = START_W'(lk_g);
          cure_d = t_ent;
          if (live_q != '0) live_d = live_q - 1'b1;
          ret_d = S_R_PREV;
          state_d = S_M0;
        end else if (real_mode) begin
          cur_d = START_W'(lk_g);
          cure_d = rd;
          if (START_W'(rd.pay) >= need_c) begin
            res_addr_d = addr_q;
            state_d = S_SP0;
          end else begin
            t_next = next_start(START_W'(lk_g), rd.pay);
            n_d = t_next;
            mem_raddr = t_next[IDX_W-1:0];
            state_d = S_RA_CHK;
          end
        end else begin
          res_usable_d = gran_bytes(START_W'(rd.pay));
          state_d = S_RESP;
        end
      end
      S_RA_CHK: begin
        t_sum = (START_W+1)'(cure_q.pay) + (START_W+1)'(HDR_GRANULES) + (START_W+1)'(rd.pay);
        if (n_q < ag_q && rd.valid && rd.free && t_sum >= {1'b0, need_c}) begin
          res_addr_d = addr_q;
          ret_d = S_SP0;
          state_d = S_M0;
        end else begin
          // move: allocate elsewhere, then release the old block
          t_bytes = gran_bytes(START_W'(cure_q.pay));
          copy_d = ({17'b0, t_bytes} < size_q) ? t_bytes : size_q[BYTE_W-1:0];
          move_d = 1'b1;
          alloc_d = 1'b1;
          s_d = '0;
          state_d = S_A_RD;
        end
      end
      S_M0: begin
        t_next = next_start(cur_q, cure_q.pay);
        n_d = t_next;
        mem_raddr = t_next[IDX_W-1:0];
        state_d = (t_next < ag_q) ? S_M1 : ret_q;
      end
      S_M1: begin
        if (rd.valid && rd.free) begin
          t_pay = cure_q.pay + PAY_W'(HDR_GRANULES) + rd.pay;
          t_ent = cure_q;
          t_ent.pay = t_pay;
          cure_d = t_ent;
          mem_we = 1'b1;
          mem_waddr = cur_q[IDX_W-1:0];
          mem_wdata = t_ent;
          state_d = S_M2;
        end else begin
          state_d = ret_q;
        end
      end
      S_M2: begin
        mem_we = 1'b1;
        mem_waddr = n_q[IDX_W-1:0];
        state_d = S_M3;
      end
      S_M3: begin
        t_next = next_start(cur_q, cure_q.pay);
        n_d = t_next;
        mem_raddr = t_next[IDX_W-1:0];
        state_d = (t_next < ag_q) ? S_M4 : ret_q;
      end
      S_M4: begin
        if (rd.valid) begin
          t_ent = rd;
          t_ent.prev = cur_q[IDX_W-1:0];
          mem_we = 1'b1;
          mem_waddr = n_q[IDX_W-1:0];
          mem_wdata = t_ent;
        end
        state_d = ret_q;
      end
      S_R_PREV: begin
        if (cur_q != '0 && START_W'(cure_q.prev) < ag_q) begin
          mem_raddr = cure_q.prev;
          n_d = START_W'(cure_q.prev);
          state_d = S_R_P1;
        end else begin
          state_d = S_RESP;
        end
      end
      S_R_P1: begin
        if (rd.valid && rd.free) begin
          cur_d = n_q;
          cure_d = rd;
          ret_d = S_RESP;
          state_d = S_M0;
        end else begin
          state_d = S_RESP;
        end
      end
      S_ST_RD, S_ST_CHK: begin
        if (state_q == S_ST_RD && s_q < ag_q) begin
          mem_raddr = s_q[IDX_W-1:0];
          state_d = S_ST_CHK;
        end else if (state_q == S_ST_CHK && rd.valid) begin
          if (rd.free) begin
            fr_d = fr_q + START_W'(rd.pay);
            if (rd.pay > lg_q) lg_d = rd.pay;
          end else begin
            us_d = us_q + START_W'(rd.pay);
          end
          s_d = next_start(s_q, rd.pay);
          state_d = S_ST_RD;
        end else begin
          res_cap_d   = gran_bytes(ag_q);
          res_alloc_d = live_q;
          res_free_d  = gran_bytes(fr_q);
          res_used_d  = gran_bytes(us_q);
          res_lg_d    = gran_bytes(START_W'(lg_q));
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (!m_tvalid_q || m_axis_tready_i) begin
          m_tvalid_d = 1'b1;
          m_tuser_d  = res_status_q;
          m_tdata_d  = {3'b0, res_lg_q, res_used_q, res_free_q, res_alloc_q, res_cap_q,
                        res_usable_q, res_copy_q, res_addr_q};
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; ret_q <= S_RESP; req_q <= '0; addr_q <= '0; size_q <= '0;
      cur_q <= '0; s_q <= '0; n_q <= '0; r_q <= '0; cure_q <= '0;
      move_q <= 1'b0; alloc_q <= 1'b0; copy_q <= '0; clr_q <= '0;
      arena_start_q <= '0; ag_q <= '0; live_q <= '0; formatted_q <= 1'b0;
      fr_q <= '0; us_q <= '0; lg_q <= '0;
      res_status_q <= '0; res_addr_q <= '0; res_copy_q <= '0; res_usable_q <= '0;
      res_cap_q <= '0; res_alloc_q <= '0; res_free_q <= '0; res_used_q <= '0;
      res_lg_q <= '0;
      m_tvalid_q <= 1'b0; m_tdata_q <= '0; m_tuser_q <= '0;
    end else begin
      state_q <= state_d; ret_q <= ret_d; req_q <= req_d; addr_q <= addr_d;
      size_q <= size_d;
      cur_q <= cur_d; s_q <= s_d; n_q <= n_d; r_q <= r_d; cure_q <= cure_d;
      move_q <= move_d; alloc_q <= alloc_d; copy_q <= copy_d; clr_q <= clr_d;
      arena_start_q <= arena_start_d; ag_q <= ag_d; live_q <= live_d;
      formatted_q <= formatted_d;
      fr_q <= fr_d; us_q <= us_d; lg_q <= lg_d;
      res_status_q <= res_status_d; res_addr_q <= res_addr_d; res_copy_q <= res_copy_d;
      res_usable_q <= res_usable_d; res_cap_q <= res_cap_d; res_alloc_q <= res_alloc_d;
      res_free_q <= res_free_d; res_used_q <= res_used_d; res_lg_q <= res_lg_d;
      m_tvalid_q <= m_tvalid_d; m_tdata_q <= m_tdata_d; m_tuser_q <= m_tuser_d;
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = m_tdata_q;
  assign m_axis_tuser_o  = m_tuser_q;

endmodule
